/* hw/rtl/rne_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rne_pkg;

    localparam int VALUE_W  = 12;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;
    localparam int N_PLACES = 4;
    localparam int PLACE_W  = 2;
    localparam int IDX_W    = 2;
    localparam int LEN_W    = 3;
    localparam int CNT_W    = $clog2(VALUE_W + 1);

    localparam logic [VALUE_W-1:0] MAX_VALID = VALUE_W'(3999);

    localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
    localparam logic [CHAR_W-1:0] CH_I    = 7'h49;
    localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
    localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
    localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
    localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
    localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;

    localparam logic [PLACE_W-1:0] PLACE_THOU = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_HUND = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_TENS = 2'd2;
    localparam logic [PLACE_W-1:0] PLACE_UNIT = 2'd3;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef t_digit [0:N_PLACES-1] t_bcd;
    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [1:0] {
        SLOT_ONE,
        SLOT_FIVE,
        SLOT_TEN
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              invalid;
    } t_out_item;

    function automatic t_len digit_len(input t_digit d);
        t_len len;
        unique case (d)
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_slot digit_slot(input t_digit d, input logic [IDX_W-1:0] i);
        t_slot slot;
        priority if (d == 4'd4) begin
            slot = (i == '0) ? SLOT_ONE : SLOT_FIVE;
        end else if (d == 4'd9) begin
            slot = (i == '0) ? SLOT_ONE : SLOT_TEN;
        end else if (d >= 4'd5) begin
            slot = (i == '0) ? SLOT_FIVE : SLOT_ONE;
        end else begin
            slot = SLOT_ONE;
        end
        return slot;
    endfunction

    function automatic logic [CHAR_W-1:0] place_sym(input logic [PLACE_W-1:0] p,
                                                    input t_slot slot);
        logic [CHAR_W-1:0] ch;
        unique case (p)
            PLACE_THOU: ch = CH_M;
            PLACE_HUND: begin
                case (slot)
                    SLOT_ONE:  ch = CH_C;
                    SLOT_FIVE: ch = CH_D;
                    default:   ch = CH_M;
                endcase
            end
            PLACE_TENS: begin
                case (slot)
                    SLOT_ONE:  ch = CH_X;
                    SLOT_FIVE: ch = CH_L;
                    default:   ch = CH_C;
                endcase
            end
            PLACE_UNIT: begin
                case (slot)
                    SLOT_ONE:  ch = CH_I;
                    SLOT_FIVE: ch = CH_V;
                    default:   ch = CH_X;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rne_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rne_in_if;
    import rne_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rne_out_if;
    import rne_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rne_bcd.sv */
`timescale 1ns / 1ps
`default_nettype none

module rne_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rne_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_done,
    output rne_pkg::t_bcd                 o_digits
);
    import rne_pkg::*;

    localparam int BCD_W = N_PLACES * DIGIT_W;

    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [BCD_W-1:0]   w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < N_PLACES; k++) begin
            if (r_bcd[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                w_adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                w_adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    assign o_done   = r_done;
    assign o_digits = t_bcd'(r_bcd);

endmodule

`default_nettype wire

/* hw/rtl/roman_numeral_encoder.sv */
// channel  dir  payload                       handshake
// i_in     in   value[11:0]                   valid/ready
// o_out    out  char_code[6:0], last, invalid valid/ready
//
// one item at a time: accept, shift-add binary to decimal, hand over, then one
// character per cycle while the output register can load, skipping zero places
// before the last nonzero one (a numeral has up to 15 characters)
// values of 0 or above 3999 skip the conversion and give one flagged result
// synchronous active-low reset; the output register lets the next item in
// while a character waits
`timescale 1ns / 1ps
`default_nettype none

module roman_numeral_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rne_in_if.sink    i_in,
    rne_out_if.source o_out
);
    import rne_pkg::*;

    t_state             r_state, n_state;
    logic               r_inv, n_inv;
    logic [PLACE_W-1:0] r_place, n_place;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic   w_accept;
    logic   w_bad;
    logic   w_start;
    logic   w_done;
    t_bcd   w_digits;
    t_digit w_cur;
    t_len   w_len;
    logic   w_idx_last;
    logic   w_tail_zero;
    logic   w_load;

    rne_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (i_in.data.value),
        .o_done   (w_done),
        .o_digits (w_digits)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_bad       = (i_in.data.value == '0) || (i_in.data.value > MAX_VALID);
    assign w_start     = w_accept && !w_bad;
    assign w_cur       = w_digits[r_place];
    assign w_len       = digit_len(w_cur);
    assign w_idx_last  = ({1'b0, r_idx} == (w_len - LEN_W'(1)));
    assign w_load      = !r_out_valid || o_out.ready;

    // no nonzero digit after the current place
    always_comb begin
        w_tail_zero = 1'b1;
        for (int k = 0; k < N_PLACES; k++) begin
            if ((PLACE_W'(k) > r_place) && (w_digits[k] != '0)) begin
                w_tail_zero = 1'b0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_inv       = r_inv;
        n_place     = r_place;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_inv   = w_bad;
                    n_place = PLACE_THOU;
                    n_idx   = '0;
                    n_state = w_bad ? S_EMIT : S_CONV;
                end
            end
            S_CONV: begin
                if (w_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                priority if (r_inv) begin
                    if (w_load) begin
                        n_out.char_code = CH_NONE;
                        n_out.last      = 1'b1;
                        n_out.invalid   = 1'b1;
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (w_len == '0) begin
                    n_place = r_place + PLACE_W'(1);
                end else if (w_load) begin
                    n_out.char_code = place_sym(r_place, digit_slot(w_cur, r_idx));
                    n_out.last      = w_idx_last && w_tail_zero;
                    n_out.invalid   = 1'b0;
                    n_out_valid     = 1'b1;
                    if (w_idx_last) begin
                        n_idx   = '0;
                        n_place = r_place + PLACE_W'(1);
                        if (w_tail_zero) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_inv   <= n_inv;
        r_place <= n_place;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/rne_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module rne_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input rne_pkg::t_out_item   i_out_data
);
    import rne_pkg::*;

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output item changed while stalled");

    // one item at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accept");

    a_inv_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.invalid |->
            i_out_data.last && (i_out_data.char_code == CH_NONE))
        else $error("invalid item not a single blank character");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.invalid |->
            (i_out_data.char_code == CH_I) || (i_out_data.char_code == CH_V) ||
            (i_out_data.char_code == CH_X) || (i_out_data.char_code == CH_L) ||
            (i_out_data.char_code == CH_C) || (i_out_data.char_code == CH_D) ||
            (i_out_data.char_code == CH_M))
        else $error("character outside the numeral set");

endmodule

bind roman_numeral_encoder rne_chk u_rne_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

/* verif/tb_roman_numeral_encoder.sv */
`timescale 1ns / 1ps

module tb_roman_numeral_encoder;
    import rne_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RESET_CYC  = 5;
    localparam int N_RANDOM   = 450;
    localparam int MAX_GAP    = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYC  = 40;

    logic i_clk;
    logic i_rst_n;

    rne_in_if  in_if ();
    rne_out_if out_if ();

    roman_numeral_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_in_item    value_q [$];
    t_out_item   char_q [$];
    t_out_item   want_char;
    int          mismatch_count;
    int          idle_cycles;
    logic        in_fire;
    logic        out_fire;
    int unsigned in_gap;
    int unsigned out_gap;
    bit          in_burst;
    bit          out_burst;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // expected characters of one numeral, most significant first
    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        int unsigned rest;
        int unsigned div;
        int unsigned d;
        logic [CHAR_W-1:0] one_c;
        logic [CHAR_W-1:0] five_c;
        logic [CHAR_W-1:0] ten_c;
        logic [CHAR_W-1:0] chars [$];
        if (v == '0 || v > MAX_VALID) begin
            char_q.push_back('{char_code: CH_NONE, last: 1'b1, invalid: 1'b1});
            return;
        end
        rest = v;
        for (int p = 0; p < N_PLACES; p++) begin
            case (PLACE_W'(p))
                PLACE_THOU: begin
                    div = 1000; one_c = CH_M; five_c = CH_M; ten_c = CH_M;
                end
                PLACE_HUND: begin
                    div = 100; one_c = CH_C; five_c = CH_D; ten_c = CH_M;
                end
                PLACE_TENS: begin
                    div = 10; one_c = CH_X; five_c = CH_L; ten_c = CH_C;
                end
                default: begin
                    div = 1; one_c = CH_I; five_c = CH_V; ten_c = CH_X;
                end
            endcase
            d = rest / div;
            rest = rest % div;
            if (d == 9) begin
                chars.push_back(one_c);
                chars.push_back(ten_c);
            end else if (d == 4) begin
                chars.push_back(one_c);
                chars.push_back(five_c);
            end else begin
                if (d >= 5) begin
                    chars.push_back(five_c);
                end
                for (int k = 0; k < int'(d % 5); k++) begin
                    chars.push_back(one_c);
                end
            end
        end
        foreach (chars[i]) begin
            char_q.push_back('{char_code: chars[i],
                               last: (i == chars.size() - 1),
                               invalid: 1'b0});
        end
    endfunction

    // wait before the next item; bursts with no idling come and go
    function automatic int unsigned draw_gap(ref bit burst);
        if ($urandom_range(0, 19) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns mismatch: %s got %0h want %0h", $time, what, got, want);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!(in_if.valid && !in_fire)) begin
            if (in_if.valid && in_fire) begin
                in_gap = draw_gap(in_burst);
            end
            if (in_gap > 0) begin
                in_gap--;
                in_if.valid <= 1'b0;
            end else if (value_q.size() > 0) begin
                in_if.valid <= 1'b1;
                in_if.data  <= value_q.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_fire) begin
                out_gap = draw_gap(out_burst);
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && in_if.valid && in_if.ready;
        out_fire <= i_rst_n && out_if.valid && out_if.ready;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_numeral(in_if.data.value);
            end
            if (out_if.valid && out_if.ready) begin
                if (char_q.size() == 0) begin
                    report_mismatch("result with nothing expected, char_code",
                                    out_if.data.char_code, 0);
                end else begin
                    want_char = char_q.pop_front();
                    if (out_if.data.char_code !== want_char.char_code) begin
                        report_mismatch("char_code", out_if.data.char_code,
                                        want_char.char_code);
                    end
                    if (out_if.data.last !== want_char.last) begin
                        report_mismatch("last", out_if.data.last, want_char.last);
                    end
                    if (out_if.data.invalid !== want_char.invalid) begin
                        report_mismatch("invalid", out_if.data.invalid,
                                        want_char.invalid);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns timeout, %0d results still expected", $time,
                         char_q.size());
                $display("tb_roman_numeral_encoder: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned v;
        int unsigned directed [] = '{0, 1, 3999, 4000, 4095, 3888, 4, 9, 5, 40, 90,
                                     400, 900, 1000, 2000, 3000, 1994, 444, 999,
                                     10, 100, 3449, 1444, 2048, 3001};
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        in_fire        = 1'b0;
        out_fire       = 1'b0;
        in_gap         = 0;
        out_gap        = 0;
        in_burst       = 1'b0;
        out_burst      = 1'b0;

        foreach (directed[i]) begin
            value_q.push_back('{value: VALUE_W'(directed[i])});
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: v = $urandom_range(1, 3999);
                6, 7: begin
                    // sparse digits, zero places in the middle
                    v = $urandom_range(0, 3) * 1000;
                    v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9) * 100;
                    v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9) * 10;
                    v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    if (v == 0) begin
                        v = $urandom_range(1, 9);
                    end
                end
                8: v = $urandom_range(4000, 4095);
                default: v = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3800, 3999);
            endcase
            value_q.push_back('{value: VALUE_W'(v)});
        end

        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (value_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_roman_numeral_encoder: PASS");
        end else begin
            $display("tb_roman_numeral_encoder: FAIL");
        end
        $finish;
    end

endmodule
